### rtl/wmam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmam_pkg
// Types and constants of the windowed memory alarm monitor.
// ----------------------------------------------------------------------------
package wmam_pkg;

  localparam int DATA_W    = 32;
  localparam int WIN_LEN_W = 5;
  localparam int PADDR_W   = 4;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_MIN_FREE   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_SWAP   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_HOLDOFF    = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LEN = 2'd3;

  localparam logic [DATA_W-1:0]    MIN_FREE_RST   = 32'd10000;
  localparam logic [DATA_W-1:0]    MAX_SWAP_RST   = 32'd0;
  localparam logic [DATA_W-1:0]    HOLDOFF_RST    = 32'd43200;
  localparam logic [WIN_LEN_W-1:0] WINDOW_LEN_RST = 5'd10;

  typedef struct packed {
    logic [DATA_W-1:0] mem_total_kb;
    logic [DATA_W-1:0] mem_free_kb;
    logic [DATA_W-1:0] swap_total_kb;
    logic [DATA_W-1:0] swap_free_kb;
    logic [DATA_W-1:0] now_seconds;
    logic              sample_complete;
  } in_item_t;

  typedef struct packed {
    logic              mem_alarm;
    logic              swap_alarm;
    logic [DATA_W-1:0] avg_free_kb;
    logic [DATA_W-1:0] swap_used_kb;
    logic              window_full;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

### rtl/windowed_memory_alarm_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_memory_alarm_monitor
// Sliding-window free-memory average and swap-use alarms with hold-off.
// ----------------------------------------------------------------------------
// Flow: an incomplete sample or one that only fills the window goes from
//   ST_IDLE to ST_DONE and then to the output register; a sample into a full
//   window also passes ST_READ and ST_DIV, where the bit-serial divider runs.
// Throughput: one sample at a time; the next is taken once the result has
//   moved to the output register.
// Reset: synchronous, active low; window empty, both alarms armed.
module windowed_memory_alarm_monitor
  import wmam_pkg::*;
#(
  parameter int WINDOW_MAX = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]    prdata,
  output logic                 pready
);

  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W = DATA_W + CNT_W;
  localparam int CMP_W = (CNT_W > WIN_LEN_W) ? CNT_W : WIN_LEN_W;

  // configuration
  logic [DATA_W-1:0]    min_free_r;
  logic [DATA_W-1:0]    max_swap_r;
  logic [DATA_W-1:0]    holdoff_r;
  logic [WIN_LEN_W-1:0] window_len_r;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  // state
  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     fill_r;
  logic [CNT_W-1:0]     oldest_r;
  logic [SUM_W-1:0]     sum_r;
  logic [DATA_W-1:0]    last_mem_r;
  logic [DATA_W-1:0]    last_swap_r;
  logic                 mem_armed_r;
  logic                 swap_armed_r;

  // per-sample holding
  logic [DATA_W-1:0]    free_r;
  logic [DATA_W-1:0]    now_r;
  out_item_t            res_r;
  out_item_t            res_acc;
  out_item_t            res_div;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  // window memory
  logic [DATA_W-1:0]    free_mem [WINDOW_MAX];
  logic [DATA_W-1:0]    mem_rd_r;
  logic                 mem_we;
  logic                 mem_re;
  logic [IDX_W-1:0]     mem_wa;
  logic [DATA_W-1:0]    mem_wd;

  logic                 accept;
  logic                 storing;
  logic                 go_read;
  logic                 div_start;
  logic                 div_done;
  logic [SUM_W-1:0]     quo;
  logic [SUM_W-1:0]     sum_upd;
  logic [CNT_W-1:0]     len_eff;
  logic [CMP_W-1:0]     len_ext;
  logic [CNT_W-1:0]     oldest_inc;
  logic                 out_free;
  logic [DATA_W-1:0]    swap_used;
  logic                 swap_fire;
  logic                 mem_fire;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_MIN_FREE:   prdata = min_free_r;
      REG_MAX_SWAP:   prdata = max_swap_r;
      REG_HOLDOFF:    prdata = holdoff_r;
      REG_WINDOW_LEN: prdata = DATA_W'(window_len_r);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_free_r   <= MIN_FREE_RST;
      max_swap_r   <= MAX_SWAP_RST;
      holdoff_r    <= HOLDOFF_RST;
      window_len_r <= WINDOW_LEN_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MIN_FREE:   min_free_r   <= pwdata;
        REG_MAX_SWAP:   max_swap_r   <= pwdata;
        REG_HOLDOFF:    holdoff_r    <= pwdata;
        REG_WINDOW_LEN: window_len_r <= pwdata[WIN_LEN_W-1:0];
        default:        ;
      endcase
    end
  end

  // clamp length to 1 .. WINDOW_MAX
  always_comb begin
    len_ext = CMP_W'(window_len_r);
    priority if (len_ext == '0) begin
      len_eff = CNT_W'(1);
    end else if (len_ext > CMP_W'(WINDOW_MAX)) begin
      len_eff = CNT_W'(WINDOW_MAX);
    end else begin
      len_eff = CNT_W'(len_ext);
    end
  end

  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign oldest_inc = oldest_r + 1'b1;
  assign sum_upd    = sum_r - SUM_W'(mem_rd_r) + SUM_W'(free_r);
  assign swap_used  = (in_data.swap_total_kb > in_data.swap_free_kb) ?
                      (in_data.swap_total_kb - in_data.swap_free_kb) : '0;
  assign swap_fire  = (swap_armed_r ||
                       ((in_data.now_seconds - last_swap_r) >= holdoff_r)) &&
                      (swap_used > max_swap_r);
  assign mem_fire   = (mem_armed_r || ((now_r - last_mem_r) >= holdoff_r)) &&
                      (quo[DATA_W-1:0] < min_free_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) begin
        state_nxt = go_read ? ST_READ : ST_DONE;
      end
      ST_READ: state_nxt = ST_DIV;
      ST_DIV:  if (div_done) begin
        state_nxt = ST_DONE;
      end
      ST_DONE: if (out_free) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = 1'b1;
    storing   = 1'b0;
    go_read   = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = oldest_r[IDX_W-1:0];
    mem_wd    = free_r;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        storing  = in_data.sample_complete && (fill_r < len_eff);
        go_read  = in_data.sample_complete && (fill_r >= len_eff);
        mem_re   = accept && go_read;
        mem_we   = accept && storing;
        mem_wa   = fill_r[IDX_W-1:0];
        mem_wd   = in_data.mem_free_kb;
      end
      ST_READ: begin
        mem_we    = 1'b1;
        div_start = 1'b1;
      end
      ST_DIV, ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      free_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd_r <= free_mem[oldest_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      oldest_r     <= '0;
      sum_r        <= '0;
      last_mem_r   <= '0;
      last_swap_r  <= '0;
      mem_armed_r  <= 1'b1;
      swap_armed_r <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && (reg_idx == REG_WINDOW_LEN)) begin
        fill_r   <= '0;
        oldest_r <= '0;
        sum_r    <= '0;
      end else if (mem_we && (state_r == ST_IDLE)) begin
        fill_r <= fill_r + 1'b1;
        sum_r  <= sum_r + SUM_W'(in_data.mem_free_kb);
      end else if (state_r == ST_READ) begin
        sum_r    <= sum_upd;
        oldest_r <= (oldest_inc >= len_eff) ? '0 : oldest_inc;
      end
      if (accept && in_data.sample_complete && swap_fire) begin
        last_swap_r  <= in_data.now_seconds;
        swap_armed_r <= 1'b0;
      end
      if ((state_r == ST_DIV) && div_done && mem_fire) begin
        last_mem_r  <= now_r;
        mem_armed_r <= 1'b0;
      end
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    res_acc = '0;
    if (in_data.sample_complete) begin
      res_acc.swap_used_kb = swap_used;
      res_acc.swap_alarm   = swap_fire;
    end
  end

  always_comb begin
    res_div             = res_r;
    res_div.window_full = 1'b1;
    res_div.avg_free_kb = quo[DATA_W-1:0];
    res_div.mem_alarm   = mem_fire;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      free_r <= in_data.mem_free_kb;
      now_r  <= in_data.now_seconds;
      res_r  <= res_acc;
    end else if ((state_r == ST_DIV) && div_done) begin
      res_r <= res_div;
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_data_r <= res_r;
    end
  end

  wmam_div #(
    .N_W (SUM_W),
    .D_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_upd),
    .divisor  (len_eff),
    .done     (div_done),
    .quotient (quo)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/wmam_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmam_div
// Restoring divider, one quotient bit per cycle; done pulses once all N_W bits are in.
// ----------------------------------------------------------------------------
module wmam_div #(
  parameter int N_W = 37,
  parameter int D_W = 5
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           done,
  output logic [N_W-1:0] quotient
);

  localparam int CW = $clog2(N_W + 1);

  logic [N_W-1:0] q_r;
  logic [D_W-1:0] rem_r;
  logic [D_W-1:0] dvs_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r;
  logic           done_r;

  logic [D_W:0]   trial;
  logic           ge;
  logic [D_W:0]   diff;
  logic [D_W-1:0] rem_nxt;
  logic [N_W-1:0] q_nxt;

  always_comb begin
    trial   = {rem_r, q_r[N_W-1]};
    ge      = trial >= {1'b0, dvs_r};
    diff    = trial - {1'b0, dvs_r};
    rem_nxt = ge ? diff[D_W-1:0] : trial[D_W-1:0];
    q_nxt   = {q_r[N_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(N_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

### rtl/wmam_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmam_checker
// Port-level checks of the windowed memory alarm monitor.
// ----------------------------------------------------------------------------
module wmam_checker
  import wmam_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result beat changed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second sample taken while one is in flight");

  a_no_avg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.window_full |->
      (out_data.avg_free_kb == '0) && !out_data.mem_alarm)
    else $error("average or memory alarm without a full window");

  a_swap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.swap_alarm |-> out_data.swap_used_kb != '0)
    else $error("swap alarm with no swap in use");

endmodule

bind windowed_memory_alarm_monitor wmam_checker u_wmam_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the windowed memory alarm monitor. A directed run
// hits the field extremes, swap saturation, window fill and the wrapping
// hold-off. Random runs then sweep several register settings, including the
// extreme ones, with random gaps and stalls on both channels. A tracker class
// predicts every result beat and compares it, field by field, in order.
// ----------------------------------------------------------------------------
module tb;
  import wmam_pkg::*;

  class alarm_tracker;
    logic [DATA_W-1:0]    min_free;
    logic [DATA_W-1:0]    max_swap;
    logic [DATA_W-1:0]    holdoff;
    logic [WIN_LEN_W-1:0] win_len;
    logic [DATA_W-1:0]    free_hist [16];
    int unsigned          oldest;
    int unsigned          fill;
    logic [35:0]          free_sum;
    logic [DATA_W-1:0]    last_mem_t;
    logic [DATA_W-1:0]    last_swap_t;
    bit                   mem_armed;
    bit                   swap_armed;
    out_item_t            due_reports [$];
    int unsigned          mismatches;

    function new();
      min_free    = MIN_FREE_RST;
      max_swap    = MAX_SWAP_RST;
      holdoff     = HOLDOFF_RST;
      win_len     = WINDOW_LEN_RST;
      oldest      = 0;
      fill        = 0;
      free_sum    = '0;
      last_mem_t  = '0;
      last_swap_t = '0;
      mem_armed   = 1'b1;
      swap_armed  = 1'b1;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_MIN_FREE: min_free = value;
        REG_MAX_SWAP: max_swap = value;
        REG_HOLDOFF:  holdoff = value;
        REG_WINDOW_LEN: begin
          win_len  = value[WIN_LEN_W-1:0];
          oldest   = 0;
          fill     = 0;
          free_sum = '0;
        end
        default: ;
      endcase
    endfunction

    function void take_sample(in_item_t s);
      out_item_t         r;
      int unsigned       len;
      int unsigned       slot;
      logic [35:0]       quot;
      logic [DATA_W-1:0] elapsed;
      r   = '0;
      len = (win_len == 0) ? 1 : ((win_len > 16) ? 16 : win_len);
      if (s.sample_complete) begin
        if (fill < len) begin
          free_hist[fill % 16] = s.mem_free_kb;
          free_sum = free_sum + s.mem_free_kb;
          fill++;
        end else begin
          slot = oldest % 16;
          free_sum = free_sum - free_hist[slot] + s.mem_free_kb;
          free_hist[slot] = s.mem_free_kb;
          oldest = (slot + 1 >= len) ? 0 : slot + 1;
          r.window_full = 1'b1;
          quot = free_sum / len;
          r.avg_free_kb = quot[DATA_W-1:0];
          elapsed = s.now_seconds - last_mem_t;
          if ((mem_armed || elapsed >= holdoff) && r.avg_free_kb < min_free) begin
            r.mem_alarm = 1'b1;
            last_mem_t  = s.now_seconds;
            mem_armed   = 1'b0;
          end
        end
        r.swap_used_kb = (s.swap_total_kb > s.swap_free_kb) ?
                         s.swap_total_kb - s.swap_free_kb : '0;
        elapsed = s.now_seconds - last_swap_t;
        if ((swap_armed || elapsed >= holdoff) && r.swap_used_kb > max_swap) begin
          r.swap_alarm = 1'b1;
          last_swap_t  = s.now_seconds;
          swap_armed   = 1'b0;
        end
      end
      due_reports.insert(due_reports.size(), r);
    endfunction

    function void compare_field(string name, logic [DATA_W-1:0] want,
                                logic [DATA_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      if (due_reports.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual %p", $time, got);
        mismatches++;
      end else begin
        want = due_reports.pop_front();
        compare_field("mem_alarm", want.mem_alarm, got.mem_alarm);
        compare_field("swap_alarm", want.swap_alarm, got.swap_alarm);
        compare_field("avg_free_kb", want.avg_free_kb, got.avg_free_kb);
        compare_field("swap_used_kb", want.swap_used_kb, got.swap_used_kb);
        compare_field("window_full", want.window_full, got.window_full);
      end
    endfunction

    function int pending();
      return due_reports.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  alarm_tracker       tracker = new();
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_stall_pct = 0;
  bit                 hold_req = 1'b0;
  int unsigned        hold_left = 0;
  logic [DATA_W-1:0]  now_s = '0;
  logic [DATA_W-1:0]  free_centre = '0;
  logic [DATA_W-1:0]  swap_centre = '0;
  int unsigned        step_max = 1;

  windowed_memory_alarm_monitor dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 300;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
      tracker.check_report(out_data);
  end

  task automatic send_sample(input in_item_t s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.take_sample(s);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    tracker.write_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  function automatic in_item_t mk(logic [DATA_W-1:0] free_kb, logic [DATA_W-1:0] swap_tot,
                                  logic [DATA_W-1:0] swap_fr, logic [DATA_W-1:0] now,
                                  logic complete);
    in_item_t s;
    s.mem_total_kb    = $urandom();
    s.mem_free_kb     = free_kb;
    s.swap_total_kb   = swap_tot;
    s.swap_free_kb    = swap_fr;
    s.now_seconds     = now;
    s.sample_complete = complete;
    return s;
  endfunction

  function automatic in_item_t random_sample();
    in_item_t    s;
    int unsigned mode;
    mode = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0)
      now_s = $urandom();
    else
      now_s = now_s + $urandom_range(0, step_max);
    s.mem_total_kb    = $urandom();
    s.now_seconds     = now_s;
    s.sample_complete = (mode >= 8);
    if (mode < 25)
      s.mem_free_kb = $urandom();
    else
      s.mem_free_kb = free_centre + $urandom_range(0, 4000) - 2000;
    if (mode % 4 == 0) begin
      s.swap_total_kb = $urandom();
      s.swap_free_kb  = $urandom();
    end else begin
      s.swap_free_kb  = $urandom();
      s.swap_total_kb = s.swap_free_kb + swap_centre + $urandom_range(0, 200) - 100;
    end
    return s;
  endfunction

  task automatic run_phase(input logic [DATA_W-1:0] min_free, input logic [DATA_W-1:0] max_swap,
                           input logic [DATA_W-1:0] hold, input logic [DATA_W-1:0] wlen,
                           input int unsigned step, input bit pressure);
    int unsigned done_n;
    in_item_t    s;
    wait_idle();
    write_reg(REG_MIN_FREE, min_free);
    write_reg(REG_MAX_SWAP, max_swap);
    write_reg(REG_HOLDOFF, hold);
    write_reg(REG_WINDOW_LEN, wlen);
    free_centre = min_free;
    swap_centre = max_swap;
    step_max    = step;
    if (pressure)
      hold_req = 1'b1;
    done_n = 0;
    while (done_n < 125) begin
      s = random_sample();
      send_sample(s);
      done_n++;
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: ignored sample, swap saturation, swap hold-off
    send_sample(mk('1, '1, '1, '1, 1'b0));
    send_sample(mk('1, '1, '0, 32'd0, 1'b1));
    send_sample(mk(32'd0, 32'd5, 32'd9, 32'd5, 1'b1));
    send_sample(mk(32'd100, 32'd100, 32'd0, 32'd43199, 1'b1));
    send_sample(mk(32'd100, 32'd100, 32'd0, 32'd43200, 1'b1));

    wait_idle();
    write_reg(REG_WINDOW_LEN, 32'd1);
    write_reg(REG_MIN_FREE, '1);
    write_reg(REG_MAX_SWAP, 32'hFFFF_FFFE);
    write_reg(REG_HOLDOFF, 32'd0);
    send_sample(mk(32'd0, 32'd0, 32'd0, 32'd7, 1'b1));
    send_sample(mk('1, 32'd0, 32'd0, 32'd8, 1'b1));
    send_sample(mk(32'hFFFF_FFFE, 32'd0, 32'd0, 32'd9, 1'b1));
    send_sample(mk(32'd0, 32'd0, 32'd0, 32'd10, 1'b1));
    send_sample(mk(32'd0, '1, 32'd0, 32'd11, 1'b1));

    // length zero acts as one; upper data bits must be dropped
    wait_idle();
    write_reg(REG_WINDOW_LEN, 32'hFFFF_FFE0);
    write_reg(REG_MIN_FREE, 32'd1000);
    write_reg(REG_HOLDOFF, 32'd100);
    send_sample(mk(32'd500, 32'd0, 32'd0, 32'hFFFF_FFC0, 1'b1));
    send_sample(mk(32'd700, 32'd0, 32'd0, 32'hFFFF_FFC0, 1'b1));
    send_sample(mk(32'd600, 32'd0, 32'd0, 32'h0000_0010, 1'b1));
    send_sample(mk(32'd600, 32'd0, 32'd0, 32'h0000_0024, 1'b1));
    send_sample(mk(32'd600, 32'd0, 32'd0, 32'h0000_0025, 1'b0));

    send_idle_pct  = 29;
    recv_stall_pct = 83;
    run_phase(32'd5000, 32'd1000, 32'd30, 32'd4, 15, 1'b0);
    run_phase('1, '1, 32'd0, 32'd16, 10, 1'b0);
    send_idle_pct  = 83;
    recv_stall_pct = 29;
    run_phase($urandom_range(1000, 1000000), $urandom_range(0, 100000), 32'd100, 32'd1, 40,
              1'b0);
    run_phase(32'd0, 32'd0, '1, 32'd31, 1000, 1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_phase($urandom(), $urandom(), 32'd10, 32'd0, 5, 1'b1);
    run_phase(32'd3000000, 32'd500000, 32'd50, $urandom_range(2, 15), 30, 1'b0);

    wait_idle();
    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
